### sv/gmc_pkg.sv
// shared types, constants and helpers for the gradient magnitude convolver
package gmc_pkg;

  localparam int MaxWidth   = 2048;
  localparam int CoeffBits  = 6;
  localparam int Taps       = 9;
  localparam int AddrW      = $clog2(MaxWidth);
  localparam int KernW      = Taps * CoeffBits;
  localparam int PixW       = 24;
  // widest magnitude of one sum: 9 * 255 * 2^(CoeffBits-1)
  localparam int SumW       = 20;
  localparam int SqW        = 2 * SumW + 1;
  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);

  // register byte addresses
  localparam logic [4:0] RegHor    = 5'd0;
  localparam logic [4:0] RegVer    = 5'd8;
  localparam logic [4:0] RegWidth  = 5'd16;
  localparam logic [4:0] RegHeight = 5'd24;

  // one queued job: the full window, its position and its frame-end flag
  typedef struct packed {
    logic [Taps-1:0][PixW-1:0] win;
    logic [10:0]               out_x;
    logic [15:0]               out_y;
    logic                      frame_end;
  } job_t;

  // channel selector for one window byte
  function automatic logic [7:0] chan_of(input logic [PixW-1:0] p, input int ch);
    return p[8*ch +: 8];
  endfunction

endpackage

### sv/gradient_magnitude_convolver.sv
// top level of the 3x3 gradient magnitude convolver
// usage:
//   pixels enter on in_valid_i / in_stall_o with blue_i, green_i, red_i in
//   raster order; one transfer per pixel. results leave on out_valid_o /
//   out_stall_i, one per interior pixel whose window is complete; border
//   pixels give nothing.
//   the front end reads the two line stores and shifts the window at one
//   pixel per cycle unless the queue stalls it; a four-entry queue feeds
//   the back end. the back end takes one interior pixel at a time: kernel
//   sums, squares, then an 8-step bit-serial square root; border pixels
//   make no job and never reach it. the registers must be written over
//   the apb port only while idle; the block does not enforce it. width
//   and height are clamped to legal ranges. reset clears counters, window
//   and handshake state; line stores are not cleared, and their contents
//   only reach a job once two full rows have been written.
//   a stalled output holds its result; the queue fills and then the input
//   is stalled.
module gradient_magnitude_convolver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  blue_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  red_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [10:0] out_x_o,
  output logic [15:0] out_y_o,
  output logic [7:0]  mag_blue_o,
  output logic [7:0]  mag_green_o,
  output logic [7:0]  mag_red_o,
  output logic        frame_end_o
);

  logic [gmc_pkg::KernW-1:0] hor_q, ver_q;
  logic [11:0] width_q;
  logic [15:0] height_q;
  logic wr_en;
  logic fq_valid, fq_stall, qb_valid, qb_stall;
  gmc_pkg::job_t fq_job, qb_job;

  // register file
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hor_q    <= '0;
      ver_q    <= '0;
      width_q  <= 12'd640;
      height_q <= 16'd480;
    end else if (wr_en) begin
      priority case (paddr)
        gmc_pkg::RegHor:    hor_q    <= pwdata[gmc_pkg::KernW-1:0];
        gmc_pkg::RegVer:    ver_q    <= pwdata[gmc_pkg::KernW-1:0];
        gmc_pkg::RegWidth:  width_q  <= pwdata[11:0];
        gmc_pkg::RegHeight: height_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    priority case (paddr)
      gmc_pkg::RegHor:    prdata = 64'(hor_q);
      gmc_pkg::RegVer:    prdata = 64'(ver_q);
      gmc_pkg::RegWidth:  prdata = 64'(width_q);
      gmc_pkg::RegHeight: prdata = 64'(height_q);
      default:            prdata = '0;
    endcase
  end

  gmc_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .blue_i, .green_i, .red_i,
    .image_width_i(width_q), .image_height_i(height_q),
    .job_valid_o(fq_valid), .job_stall_i(fq_stall), .job_o(fq_job)
  );

  gmc_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(fq_valid), .wr_stall_o(fq_stall), .wr_data_i(fq_job),
    .rd_valid_o(qb_valid), .rd_stall_i(qb_stall), .rd_data_o(qb_job)
  );

  gmc_back u_back (
    .clk_i, .rst_ni, .hor_kernel_i(hor_q), .ver_kernel_i(ver_q),
    .job_valid_i(qb_valid), .job_stall_o(qb_stall), .job_i(qb_job),
    .out_valid_o, .out_stall_i, .out_x_o, .out_y_o,
    .mag_blue_o, .mag_green_o, .mag_red_o, .frame_end_o
  );

`ifndef SYNTHESIS
  // results never sit in the left border column
  a_out_x_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_x_o != 11'd0) else $error("border column emitted");
  // a stalled result stays valid and holds its red magnitude
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(mag_red_o))
    else $error("stalled result changed");
  // the front holds its job while the queue stalls it
  a_queue_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fq_valid && fq_stall |=> fq_valid) else $error("job lost at queue");
`endif

endmodule

### sv/gmc_front.sv
// front end: line stores, window shift and interior pixel classification
module gmc_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [7:0]                 blue_i,
  input  logic [7:0]                 green_i,
  input  logic [7:0]                 red_i,
  input  logic [11:0]                image_width_i,
  input  logic [15:0]                image_height_i,
  output logic                       job_valid_o,
  input  logic                       job_stall_i,
  output gmc_pkg::job_t              job_o
);

  logic [gmc_pkg::PixW-1:0] store_a [gmc_pkg::MaxWidth];
  logic [gmc_pkg::PixW-1:0] store_b [gmc_pkg::MaxWidth];

  // stage 1: pixel held while the stores are read
  logic                           s1_valid_q;
  logic [gmc_pkg::PixW-1:0]       s1_pix_q;
  logic [gmc_pkg::AddrW-1:0]      s1_addr_q;
  logic                           s1_emit_q;
  logic                           s1_fe_q;
  logic [10:0]                    s1_x_q;
  logic [15:0]                    s1_y_q;
  logic [gmc_pkg::PixW-1:0]       rd_a_q, rd_b_q;

  logic [10:0] col_q, col_d;
  logic [15:0] row_q, row_d;
  logic [11:0] eff_w;
  logic [15:0] eff_h;
  logic        last_col, accept, advance;
  logic [gmc_pkg::Taps-1:0][gmc_pkg::PixW-1:0] win_q, win_d;
  logic        job_valid_q;
  gmc_pkg::job_t job_q;

  assign eff_w = (image_width_i < 12'd3) ? 12'd3 :
                 ((image_width_i > 12'(gmc_pkg::MaxWidth)) ? 12'(gmc_pkg::MaxWidth)
                                                           : image_width_i);
  assign eff_h = (image_height_i < 16'd3) ? 16'd3 : image_height_i;
  assign last_col = ({1'b0, col_q} + 12'd1) >= eff_w;

  // a stage moves when its output slot is free or leaving
  assign advance    = !job_valid_q || !job_stall_i;
  assign in_stall_o = s1_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  // position counters
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = (row_q + 16'd1 >= eff_h) ? 16'd0 : row_q + 16'd1;
      end else begin
        col_d = col_q + 11'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (accept)       s1_valid_q <= 1'b1;
      else if (advance) s1_valid_q <= 1'b0;
    end
  end

  // stage 1 payload and store reads; column count stays below MaxWidth
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q  <= {red_i, green_i, blue_i};
      s1_addr_q <= col_q[gmc_pkg::AddrW-1:0];
      s1_emit_q <= (col_q >= 11'd2) && (row_q >= 16'd2);
      s1_fe_q   <= last_col && ({1'b0, row_q} + 17'd1 >= {1'b0, eff_h});
      s1_x_q    <= col_q - 11'd1;
      s1_y_q    <= row_q - 16'd1;
      rd_a_q    <= store_a[col_q[gmc_pkg::AddrW-1:0]];
      rd_b_q    <= store_b[col_q[gmc_pkg::AddrW-1:0]];
    end
  end

  // store update as the pixel leaves stage 1
  always_ff @(posedge clk_i) begin
    if (s1_valid_q && advance) begin
      store_a[s1_addr_q] <= s1_pix_q;
      store_b[s1_addr_q] <= rd_a_q;
    end
  end

  // window shift: taps are row-major, column 2 is newest
  always_comb begin
    win_d = win_q;
    for (int r = 0; r < 3; r++) begin
      win_d[r*3]   = win_q[r*3+1];
      win_d[r*3+1] = win_q[r*3+2];
    end
    win_d[2] = rd_b_q;
    win_d[5] = rd_a_q;
    win_d[8] = s1_pix_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= '0;
      job_valid_q <= 1'b0;
    end else begin
      if (s1_valid_q && advance) win_q <= win_d;
      if (advance) job_valid_q <= s1_valid_q && s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && advance) begin
      job_q.win       <= win_d;
      job_q.out_x     <= s1_x_q;
      job_q.out_y     <= s1_y_q;
      job_q.frame_end <= s1_fe_q;
    end
  end

  assign job_valid_o = job_valid_q;
  assign job_o       = job_q;

endmodule

### sv/gmc_queue.sv
// short job queue between front and back end
module gmc_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_stall_o,
  input  gmc_pkg::job_t wr_data_i,
  output logic          rd_valid_o,
  input  logic          rd_stall_i,
  output gmc_pkg::job_t rd_data_o
);

  gmc_pkg::job_t slots_q [gmc_pkg::QueueDepth];
  logic [gmc_pkg::QPtrW-1:0] wp_q, rp_q;
  logic [gmc_pkg::QPtrW:0]   cnt_q;
  logic push, pop;

  assign wr_stall_o = (cnt_q == (gmc_pkg::QPtrW+1)'(gmc_pkg::QueueDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign push       = wr_valid_i && !wr_stall_o;
  assign pop        = rd_valid_o && !rd_stall_i;
  assign rd_data_o  = slots_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) slots_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + 1'b1;
      if (pop)  rp_q <= rp_q + 1'b1;
      unique case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

### sv/gmc_back.sv
// back end: kernel sums, squares and bit-serial square root per channel
module gmc_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [gmc_pkg::KernW-1:0] hor_kernel_i,
  input  logic [gmc_pkg::KernW-1:0] ver_kernel_i,
  input  logic                      job_valid_i,
  output logic                      job_stall_o,
  input  gmc_pkg::job_t             job_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [10:0]               out_x_o,
  output logic [15:0]               out_y_o,
  output logic [7:0]                mag_blue_o,
  output logic [7:0]                mag_green_o,
  output logic [7:0]                mag_red_o,
  output logic                      frame_end_o
);

  typedef enum logic [2:0] {
    BK_IDLE, BK_SUM, BK_SQ, BK_ROOT, BK_DONE
  } bk_state_e;

  bk_state_e st_q, st_d;
  gmc_pkg::job_t job_q;
  logic signed [gmc_pkg::SumW-1:0] hs_q [3], vs_q [3];
  logic [gmc_pkg::SqW-1:0]         sq_q [3];
  logic [7:0]                      root_q [3];
  logic [2:0]                      bit_q;
  logic                            take, out_valid_q;
  logic [10:0] ox_q;
  logic [15:0] oy_q;
  logic [7:0]  mb_q, mg_q, mr_q;
  logic        fe_q;

  // one accumulating state: one job at a time, output register decoupled
  assign job_stall_o = (st_q != BK_IDLE);
  assign take        = job_valid_i && (st_q == BK_IDLE);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      BK_IDLE: if (job_valid_i) st_d = BK_SUM;
      BK_SUM:  st_d = BK_SQ;
      BK_SQ:   st_d = BK_ROOT;
      BK_ROOT: if (bit_q == 3'd0) st_d = BK_DONE;
      BK_DONE: if (!out_valid_q || !out_stall_i) st_d = BK_IDLE;
      default: st_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= BK_IDLE;
      out_valid_q <= 1'b0;
      bit_q       <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == BK_SQ) bit_q <= 3'd7;
      else if (st_q == BK_ROOT && bit_q != 3'd0) bit_q <= bit_q - 3'd1;
      if (st_q == BK_DONE && (!out_valid_q || !out_stall_i)) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // datapath per channel
  always_ff @(posedge clk_i) begin
    if (take) job_q <= job_i;
    for (int ch = 0; ch < 3; ch++) begin
      logic signed [gmc_pkg::SumW-1:0] h, v;
      logic [7:0] t;
      h = '0;
      v = '0;
      t = root_q[ch] | (8'd1 << bit_q);
      if (st_q == BK_SUM) begin
        for (int k = 0; k < gmc_pkg::Taps; k++) begin
          h = h + gmc_pkg::SumW'($signed(hor_kernel_i[k*gmc_pkg::CoeffBits +: gmc_pkg::CoeffBits])
                * $signed({1'b0, gmc_pkg::chan_of(job_q.win[k], ch)}));
          v = v + gmc_pkg::SumW'($signed(ver_kernel_i[k*gmc_pkg::CoeffBits +: gmc_pkg::CoeffBits])
                * $signed({1'b0, gmc_pkg::chan_of(job_q.win[k], ch)}));
        end
        hs_q[ch] <= h;
        vs_q[ch] <= v;
      end
      if (st_q == BK_SQ) begin
        sq_q[ch]   <= gmc_pkg::SqW'($unsigned(gmc_pkg::SqW'(hs_q[ch]) * gmc_pkg::SqW'(hs_q[ch])))
                    + gmc_pkg::SqW'($unsigned(gmc_pkg::SqW'(vs_q[ch]) * gmc_pkg::SqW'(vs_q[ch])));
        root_q[ch] <= '0;
      end
      if (st_q == BK_ROOT) begin
        if (gmc_pkg::SqW'(16'(t) * 16'(t)) <= sq_q[ch]) root_q[ch] <= t;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (st_q == BK_DONE && (!out_valid_q || !out_stall_i)) begin
      ox_q <= job_q.out_x;
      oy_q <= job_q.out_y;
      fe_q <= job_q.frame_end;
      mb_q <= (sq_q[0] >= gmc_pkg::SqW'(65536)) ? 8'd255 : root_q[0];
      mg_q <= (sq_q[1] >= gmc_pkg::SqW'(65536)) ? 8'd255 : root_q[1];
      mr_q <= (sq_q[2] >= gmc_pkg::SqW'(65536)) ? 8'd255 : root_q[2];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = ox_q;
  assign out_y_o     = oy_q;
  assign mag_blue_o  = mb_q;
  assign mag_green_o = mg_q;
  assign mag_red_o   = mr_q;
  assign frame_end_o = fe_q;

endmodule

### verif/testbench.sv
// self-checking testbench for the gradient magnitude convolver
`timescale 1ns / 100ps

module testbench;

  typedef struct packed {
    bit [10:0] x;
    bit [15:0] y;
    bit [7:0]  mag_b;
    bit [7:0]  mag_g;
    bit [7:0]  mag_r;
    bit        last;
  } edge_result_t;

  // predictor of the convolver plus the queue of pending gradient results
  class gmc_scoreboard;
    bit [23:0]    prev_row [gmc_pkg::MaxWidth];
    bit [23:0]    older_row [gmc_pkg::MaxWidth];
    bit [23:0]    win [3][3];
    int unsigned  col;
    int unsigned  row;
    bit [53:0]    hor_k;
    bit [53:0]    ver_k;
    int unsigned  width_reg;
    int unsigned  height_reg;
    edge_result_t pending_mags[$];
    int           errors;
    int           checked;

    function new();
      hor_k = '0;
      ver_k = '0;
      width_reg = 640;
      height_reg = 480;
      col = 0;
      row = 0;
      errors = 0;
      checked = 0;
      foreach (win[r, c]) win[r][c] = '0;
    endfunction

    function int coeff(bit [53:0] kern, int k);
      bit signed [5:0] raw;
      raw = kern[6*k +: 6];
      return raw;
    endfunction

    // floor square root, saturated at 255
    function bit [7:0] root_of(longint h, longint v);
      longint s;
      int     acc;
      s = h * h + v * v;
      if (s >= 65536) return 8'd255;
      acc = 0;
      for (int b = 128; b != 0; b = b >> 1)
        if ((acc | b) * (acc | b) <= s) acc = acc | b;
      return acc[7:0];
    endfunction

    // advance the model by one accepted pixel
    function void note_pixel(bit [7:0] b, bit [7:0] g, bit [7:0] r);
      int unsigned  w;
      int unsigned  hgt;
      bit [23:0]    pix;
      edge_result_t res;
      longint       hs;
      longint       vs;
      bit [7:0]     mags [3];
      bit           last_col;
      w = width_reg < 3 ? 3 : (width_reg > gmc_pkg::MaxWidth ? gmc_pkg::MaxWidth : width_reg);
      hgt = height_reg < 3 ? 3 : height_reg;
      pix = {r, g, b};
      last_col = (col + 1 >= w);
      for (int i = 0; i < 3; i++) begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
      end
      win[0][2] = older_row[col];
      win[1][2] = prev_row[col];
      win[2][2] = pix;
      older_row[col] = prev_row[col];
      prev_row[col] = pix;
      if (col >= 2 && row >= 2) begin
        for (int ch = 0; ch < 3; ch++) begin
          hs = 0;
          vs = 0;
          for (int k = 0; k < 9; k++) begin
            hs += coeff(hor_k, k) * longint'(win[k/3][k%3][8*ch +: 8]);
            vs += coeff(ver_k, k) * longint'(win[k/3][k%3][8*ch +: 8]);
          end
          mags[ch] = root_of(hs, vs);
        end
        res.x = 11'(col - 1);
        res.y = 16'(row - 1);
        res.mag_b = mags[0];
        res.mag_g = mags[1];
        res.mag_r = mags[2];
        res.last = last_col && (row + 1 >= hgt);
        pending_mags.push_back(res);
      end
      if (last_col) begin
        col = 0;
        row = row + 1;
        if (row >= hgt) row = 0;
      end else begin
        col = col + 1;
      end
    endfunction

    // compare one output transfer with the oldest expectation
    function void check_result(edge_result_t got);
      edge_result_t exp_r;
      checked++;
      if (pending_mags.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d", $time, got.x, got.y);
        errors++;
        return;
      end
      exp_r = pending_mags.pop_front();
      if (got.x != exp_r.x)
        $display("%0t: out_x expected %0d actual %0d", $time, exp_r.x, got.x);
      if (got.y != exp_r.y)
        $display("%0t: out_y expected %0d actual %0d", $time, exp_r.y, got.y);
      if (got.mag_b != exp_r.mag_b)
        $display("%0t: mag_blue expected %0d actual %0d", $time, exp_r.mag_b, got.mag_b);
      if (got.mag_g != exp_r.mag_g)
        $display("%0t: mag_green expected %0d actual %0d", $time, exp_r.mag_g, got.mag_g);
      if (got.mag_r != exp_r.mag_r)
        $display("%0t: mag_red expected %0d actual %0d", $time, exp_r.mag_r, got.mag_r);
      if (got.last != exp_r.last)
        $display("%0t: frame_end expected %0d actual %0d", $time, exp_r.last, got.last);
      if (got != exp_r) errors++;
    endfunction
  endclass

  localparam int WatchdogLimit = 3000;
  localparam int LongHold      = 400;
  localparam int SettleCycles  = 40;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  blue_i;
  logic [7:0]  green_i;
  logic [7:0]  red_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [10:0] out_x_o;
  logic [15:0] out_y_o;
  logic [7:0]  mag_blue_o;
  logic [7:0]  mag_green_o;
  logic [7:0]  mag_red_o;
  logic        frame_end_o;

  gmc_scoreboard sb;
  bit            tx_idle;
  bit            rx_idle;
  bit            hold_req;
  int            pixels_sent;
  int            idle_cycles;
  int            frames_run;

  gradient_magnitude_convolver DUT (.*);

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // input and output transfer monitors
  always @(posedge clk_i) begin
    edge_result_t got;
    if (rst_ni && in_valid_i && !in_stall_o) sb.note_pixel(blue_i, green_i, red_i);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.x = out_x_o;
      got.y = out_y_o;
      got.mag_b = mag_blue_o;
      got.mag_g = mag_green_o;
      got.mag_r = mag_red_o;
      got.last = frame_end_o;
      sb.check_result(got);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: random stalls, one long hold on request
  initial begin
    int n;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (LongHold) @(posedge clk_i);
      end else begin
        n = rx_idle ? $urandom_range(0, 12) : 0;
        if (n > 0) begin
          out_stall_i <= 1'b1;
          repeat (n) @(posedge clk_i);
        end
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // setup and access phase, then psel and penable dropped to idle
  task automatic reg_write(logic [4:0] addr, logic [63:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // program all four registers and mirror them in the predictor
  task automatic configure(bit [53:0] hk, bit [53:0] vk, bit [11:0] w, bit [15:0] h);
    reg_write(gmc_pkg::RegHor, 64'(hk));
    reg_write(gmc_pkg::RegVer, 64'(vk));
    reg_write(gmc_pkg::RegWidth, 64'(w));
    reg_write(gmc_pkg::RegHeight, 64'(h));
    sb.hor_k = hk;
    sb.ver_k = vk;
    sb.width_reg = w;
    sb.height_reg = h;
  endtask

  // one pixel transfer with a random gap in front
  task automatic send_pixel(bit [7:0] b, bit [7:0] g, bit [7:0] r);
    int n;
    n = tx_idle ? $urandom_range(0, 12) : 0;
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    blue_i <= b;
    green_i <= g;
    red_i <= r;
    do @(posedge clk_i); while (in_stall_o);
    pixels_sent++;
  endtask

  // sender pause until every result is back and the pipeline has settled
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_mags.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic bit [53:0] pack_kernel(int c0, int c1, int c2, int c3, int c4,
                                            int c5, int c6, int c7, int c8);
    int        cs [9];
    bit [53:0] k;
    cs = '{c0, c1, c2, c3, c4, c5, c6, c7, c8};
    for (int i = 0; i < 9; i++) k[6*i +: 6] = cs[i][5:0];
    return k;
  endfunction

  function automatic bit [53:0] random_kernel();
    bit [53:0] k;
    if ($urandom_range(0, 3) == 0) begin
      k = 54'({$urandom, $urandom});
    end else begin
      for (int i = 0; i < 9; i++) k[6*i +: 6] = 6'($signed($urandom_range(0, 6)) - 3);
    end
    return k;
  endfunction

  // random pixel, sometimes flat or extreme to make gradients small or large
  task automatic send_random_pixel();
    case ($urandom_range(0, 5))
      0: send_pixel(8'hff, 8'hff, 8'hff);
      1: send_pixel(8'h00, 8'h00, 8'h00);
      default: send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    endcase
  endtask

  task automatic run_frame(int w, int h);
    for (int i = 0; i < w * h; i++) send_random_pixel();
    frames_run++;
  endtask

  initial begin
    int w;
    int h;
    int phase;
    sb = new();
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    blue_i = '0;
    green_i = '0;
    red_i = '0;
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    hold_req = 1'b0;
    pixels_sent = 0;
    idle_cycles = 0;
    frames_run = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // saturation: extreme kernels, clamped width and height, all-white frame
    configure({9{6'b100000}}, {9{6'b011111}}, 12'd0, 16'd2);
    for (int i = 0; i < 9; i++) send_pixel(8'hff, 8'hff, 8'hff);
    drain();

    // sobel on a vertical edge with a black, white, gray mix, 4x3 frame
    configure(pack_kernel(-1, 0, 1, -2, 0, 2, -1, 0, 1),
              pack_kernel(-1, -2, -1, 0, 0, 0, 1, 2, 1), 12'd4, 16'd3);
    for (int i = 0; i < 12; i++) begin
      if (i % 4 < 2) send_pixel(8'h00, 8'h80, 8'hff);
      else send_pixel(8'hff, 8'h7f, 8'h00);
    end
    drain();

    // random phases of whole frames with random idling on both sides
    phase = 0;
    while (pixels_sent < 1580) begin
      w = $urandom_range(3, 9);
      h = $urandom_range(3, 6);
      // long hold phase uses the largest frame so the block fills up
      if (phase == 2) begin
        w = 9;
        h = 6;
      end
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
      configure(random_kernel(), random_kernel(), 12'(w), 16'(h));
      if (phase == 2) begin
        tx_idle = 1'b0;
        hold_req = 1'b1;
      end
      repeat ($urandom_range(1, 3)) run_frame(w, h);
      drain();
      phase++;
    end

    // tallest height: partial frame only, nothing written afterwards
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    configure(random_kernel(), random_kernel(), 12'd5, 16'hffff);
    for (int i = 0; i < 150; i++) send_random_pixel();
    drain();

    if (sb.pending_mags.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending_mags.size());
      sb.errors++;
    end
    $display("covered %0d pixels in %0d random frames plus directed saturation and edges,",
             pixels_sent, frames_run);
    $display("checked %0d results over clamped, extreme and random register settings",
             sb.checked);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
